// ===== src/jhcs_pkg.sv =====
`default_nettype none
package jhcs_pkg;

  localparam int NJ = 5;

  typedef enum logic [1:0] {
    MD_VEL  = 2'd0,
    MD_CUR  = 2'd1,
    MD_REF  = 2'd2,
    MD_VOLT = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    REG_REVERSE = 2'd0,
    REG_SPEED   = 2'd1,
    REG_HOLD    = 2'd2
  } reg_idx_t;

  localparam logic signed [15:0] STILL_RPM  = 16'sd5;
  localparam logic signed [31:0] COUNT_TOL  = 32'sd3;
  localparam logic [2:0]         HOLD_ITEMS = 3'd4;
  localparam logic [2:0]         CNT3_MAX   = 3'd7;
  localparam logic [11:0]        MS_MAX     = 12'd4095;

  typedef struct packed {
    logic [4:0]  reverse_mask;
    logic [14:0] search_speed;
    logic [14:0] hold_current;
  } cfg_t;

  typedef struct packed {
    logic               moving;
    logic               count_ok;
    mode_t              mode;
    logic signed [15:0] value;
  } lane_res_t;

endpackage
`default_nettype wire

// ===== src/jhcs_if.sv =====
`default_nettype none
interface jhcs_in_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic signed [15:0] speed_0;
  logic signed [15:0] speed_1;
  logic signed [15:0] speed_2;
  logic signed [15:0] speed_3;
  logic signed [15:0] speed_4;
  logic signed [31:0] count_0;
  logic signed [31:0] count_1;
  logic signed [31:0] count_2;
  logic signed [31:0] count_3;
  logic signed [31:0] count_4;

  modport source (output valid, kind, speed_0, speed_1, speed_2, speed_3, speed_4,
                  count_0, count_1, count_2, count_3, count_4, input ready);
  modport sink (input valid, kind, speed_0, speed_1, speed_2, speed_3, speed_4,
                count_0, count_1, count_2, count_3, count_4, output ready);
endinterface

interface jhcs_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         mode_0;
  logic [1:0]         mode_1;
  logic [1:0]         mode_2;
  logic [1:0]         mode_3;
  logic [1:0]         mode_4;
  logic signed [15:0] value_0;
  logic signed [15:0] value_1;
  logic signed [15:0] value_2;
  logic signed [15:0] value_3;
  logic signed [15:0] value_4;
  logic               done_res;
  logic               failed;

  modport source (output valid, mode_0, mode_1, mode_2, mode_3, mode_4,
                  value_0, value_1, value_2, value_3, value_4, done_res, failed,
                  input ready);
  modport sink (input valid, mode_0, mode_1, mode_2, mode_3, mode_4,
                value_0, value_1, value_2, value_3, value_4, done_res, failed,
                output ready);
endinterface
`default_nettype wire

// ===== src/jhcs_cfg.sv =====
`default_nettype none
module jhcs_cfg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [3:0]    cfg_paddr,
  input  wire logic [31:0]   cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output jhcs_pkg::cfg_t     cfg
);

  jhcs_pkg::cfg_t cfg_r;
  logic           wr_en;
  logic [1:0]     idx;

  assign cfg_pready = 1'b1;
  assign idx        = cfg_paddr[3:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      case (idx)
        jhcs_pkg::REG_REVERSE: cfg_r.reverse_mask <= cfg_pwdata[4:0];
        jhcs_pkg::REG_SPEED:   cfg_r.search_speed <= cfg_pwdata[14:0];
        jhcs_pkg::REG_HOLD:    cfg_r.hold_current <= cfg_pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      jhcs_pkg::REG_REVERSE: cfg_prdata = {27'd0, cfg_r.reverse_mask};
      jhcs_pkg::REG_SPEED:   cfg_prdata = {17'd0, cfg_r.search_speed};
      jhcs_pkg::REG_HOLD:    cfg_prdata = {17'd0, cfg_r.hold_current};
      default:               cfg_prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

// ===== src/jhcs_lane.sv =====
`default_nettype none
module jhcs_lane #(
  parameter int LANE        = 0,
  parameter int STOP_CYCLES = 5
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               upd,
  input  wire jhcs_pkg::cfg_t     cfg,
  input  wire logic signed [15:0] speed,
  input  wire logic signed [31:0] count,
  output jhcs_pkg::lane_res_t     res
);

  localparam logic [2:0] STOP_C = 3'(STOP_CYCLES);

  logic       moving_r, moving_nxt;
  logic [2:0] stop_r, stop_nxt;
  logic       still;
  logic [2:0] stop_sat;
  logic [14:0] mag;

  assign still    = (speed > -jhcs_pkg::STILL_RPM) && (speed < jhcs_pkg::STILL_RPM);
  assign stop_sat = (stop_r == jhcs_pkg::CNT3_MAX) ? stop_r : stop_r + 3'd1;

  always_comb begin
    stop_nxt   = stop_r;
    moving_nxt = moving_r;
    if (upd && moving_r) begin
      stop_nxt   = still ? stop_sat : 3'd0;
      moving_nxt = !(stop_nxt >= STOP_C);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      moving_r <= 1'b1;
      stop_r   <= 3'd0;
    end else begin
      moving_r <= moving_nxt;
      stop_r   <= stop_nxt;
    end
  end

  // Command follows the moving state as it stands after this transfer
  assign mag          = moving_nxt ? cfg.search_speed : cfg.hold_current;
  assign res.moving   = moving_nxt;
  assign res.count_ok = (count >= -jhcs_pkg::COUNT_TOL) && (count <= jhcs_pkg::COUNT_TOL);
  assign res.mode     = moving_nxt ? jhcs_pkg::MD_VEL : jhcs_pkg::MD_CUR;
  assign res.value    = cfg.reverse_mask[LANE] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

endmodule
`default_nettype wire

// ===== src/joint_homing_calibration_sequencer.sv =====
// Five-joint end-stop homing and encoder zeroing sequencer.
// in_chan (valid/ready) carries either a millisecond tick (kind 0) or a control
// item (kind 1) with five motor speeds and five encoder counts. Each control
// item yields exactly one command set on out_chan; ticks yield nothing and
// only advance a saturating millisecond counter.
// Five joint lanes evaluate stop detection, count tolerance and setpoints in
// parallel; the merge logic here picks the command set by phase.
// A control item's commands are registered and valid on out_chan the cycle after
// its transfer. Throughput: one item per cycle; in_chan.ready stays high while the
// output register is empty or being drained the same cycle.
// When out_chan stalls, the command set holds in the output register and
// in_chan.ready drops until it is taken.
// Reset (rst_n low, synchronous) returns to the search phase with all joints
// moving, counters zero and configuration registers zero.
// Registers via APB on cfg_*: 0x0 reverse_mask, 0x4 search_speed,
// 0x8 hold_current; writes complete in the access cycle, pready is tied high.
`default_nettype none
module joint_homing_calibration_sequencer #(
  parameter int SETTLE_MS      = 200,
  parameter int REF_TIMEOUT_MS = 2000,
  parameter int STOP_CYCLES    = 5
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  jhcs_in_if.sink          in_chan,
  jhcs_out_if.source       out_chan,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int NJ = jhcs_pkg::NJ;
  localparam logic [11:0] SETTLE_C  = 12'(SETTLE_MS);
  localparam logic [11:0] TIMEOUT_C = 12'(REF_TIMEOUT_MS);

  typedef enum logic [1:0] {
    PH_SEARCH  = 2'd0,
    PH_REFWAIT = 2'd1,
    PH_DONE    = 2'd2,
    PH_FAILED  = 2'd3
  } phase_t;

  jhcs_pkg::cfg_t      cfg;
  jhcs_pkg::lane_res_t res [NJ];
  logic signed [15:0]  speed_a [NJ];
  logic signed [31:0]  count_a [NJ];

  phase_t      phase_r, phase_nxt;
  logic [11:0] elapsed_r, elapsed_nxt;
  logic [2:0]  hold_r, hold_nxt;

  logic               out_valid_r, out_valid_nxt;
  jhcs_pkg::mode_t    mode_r [NJ];
  jhcs_pkg::mode_t    mode_nxt [NJ];
  logic signed [15:0] value_r [NJ];
  logic signed [15:0] value_nxt [NJ];
  logic               done_r, done_nxt, failed_r, failed_nxt;

  logic in_xfer, ctl_xfer, tick_xfer, hold_go, upd;
  logic any_moving, all_ok;

  jhcs_cfg u_cfg (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready, .cfg
  );

  assign speed_a[0] = in_chan.speed_0;
  assign speed_a[1] = in_chan.speed_1;
  assign speed_a[2] = in_chan.speed_2;
  assign speed_a[3] = in_chan.speed_3;
  assign speed_a[4] = in_chan.speed_4;
  assign count_a[0] = in_chan.count_0;
  assign count_a[1] = in_chan.count_1;
  assign count_a[2] = in_chan.count_2;
  assign count_a[3] = in_chan.count_3;
  assign count_a[4] = in_chan.count_4;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign in_xfer   = in_chan.valid && in_chan.ready;
  assign ctl_xfer  = in_xfer && in_chan.kind;
  assign tick_xfer = in_xfer && !in_chan.kind;
  assign hold_go   = hold_r >= jhcs_pkg::HOLD_ITEMS;
  assign upd       = ctl_xfer && (phase_r == PH_SEARCH) && !hold_go && (elapsed_r >= SETTLE_C);

  for (genvar j = 0; j < NJ; j++) begin : g_lane
    jhcs_lane #(.LANE(j), .STOP_CYCLES(STOP_CYCLES)) u_lane (
      .clk, .rst_n, .upd, .cfg, .speed(speed_a[j]), .count(count_a[j]), .res(res[j])
    );
  end

  always_comb begin
    any_moving = 1'b0;
    all_ok     = 1'b1;
    for (int j = 0; j < NJ; j++) begin
      any_moving = any_moving | res[j].moving;
      all_ok     = all_ok & res[j].count_ok;
    end
  end

  // Merge lane results by phase
  always_comb begin
    phase_nxt     = phase_r;
    elapsed_nxt   = elapsed_r;
    hold_nxt      = hold_r;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    mode_nxt      = mode_r;
    value_nxt     = value_r;
    done_nxt      = done_r;
    failed_nxt    = failed_r;

    if (tick_xfer && (elapsed_r != jhcs_pkg::MS_MAX)) begin
      elapsed_nxt = elapsed_r + 12'd1;
    end

    if (ctl_xfer) begin
      out_valid_nxt = 1'b1;
      done_nxt      = 1'b0;
      failed_nxt    = 1'b0;
      for (int j = 0; j < NJ; j++) begin
        mode_nxt[j]  = jhcs_pkg::MD_VOLT;
        value_nxt[j] = 16'sd0;
      end
      case (phase_r)
        PH_SEARCH: begin
          if (hold_go) begin
            for (int j = 0; j < NJ; j++) mode_nxt[j] = jhcs_pkg::MD_REF;
            elapsed_nxt = 12'd0;
            phase_nxt   = PH_REFWAIT;
          end else begin
            if (upd) begin
              if (any_moving) hold_nxt = 3'd0;
              else if (hold_r != jhcs_pkg::CNT3_MAX) hold_nxt = hold_r + 3'd1;
            end
            for (int j = 0; j < NJ; j++) begin
              mode_nxt[j]  = res[j].mode;
              value_nxt[j] = res[j].value;
            end
          end
        end
        PH_REFWAIT: begin
          if (elapsed_r > TIMEOUT_C) begin
            phase_nxt  = PH_FAILED;
            failed_nxt = 1'b1;
          end else if (!all_ok) begin
            for (int j = 0; j < NJ; j++) mode_nxt[j] = jhcs_pkg::MD_REF;
          end else begin
            phase_nxt = PH_DONE;
            done_nxt  = 1'b1;
          end
        end
        PH_DONE:   done_nxt   = 1'b1;
        PH_FAILED: failed_nxt = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_SEARCH;
      elapsed_r   <= 12'd0;
      hold_r      <= 3'd0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      elapsed_r   <= elapsed_nxt;
      hold_r      <= hold_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mode_r   <= mode_nxt;
    value_r  <= value_nxt;
    done_r   <= done_nxt;
    failed_r <= failed_nxt;
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.mode_0   = mode_r[0];
  assign out_chan.mode_1   = mode_r[1];
  assign out_chan.mode_2   = mode_r[2];
  assign out_chan.mode_3   = mode_r[3];
  assign out_chan.mode_4   = mode_r[4];
  assign out_chan.value_0  = value_r[0];
  assign out_chan.value_1  = value_r[1];
  assign out_chan.value_2  = value_r[2];
  assign out_chan.value_3  = value_r[3];
  assign out_chan.value_4  = value_r[4];
  assign out_chan.done_res = done_r;
  assign out_chan.failed   = failed_r;

  a_done_fail_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(done_r && failed_r))
    else $error("done and failed flagged together");

  a_fail_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_FAILED) |=> (phase_r == PH_FAILED))
    else $error("failure phase left without reset");

  a_done_volt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (done_r || failed_r)) |->
      (mode_r[0] == jhcs_pkg::MD_VOLT) && (mode_r[4] == jhcs_pkg::MD_VOLT) &&
      (value_r[0] == 16'sd0) && (value_r[4] == 16'sd0))
    else $error("terminal result carries a non-voltage command");

  a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
    (tick_xfer && (elapsed_r != jhcs_pkg::MS_MAX)) |=>
      (elapsed_r == $past(elapsed_r) + 12'd1))
    else $error("tick did not advance millisecond counter");

endmodule
`default_nettype wire

// ===== tb/sv/tb_joint_homing_calibration_sequencer.sv =====
`timescale 1ns / 1ps
module tb_joint_homing_calibration_sequencer;

  localparam int NJ              = jhcs_pkg::NJ;
  localparam int SETTLE_MS       = 200;
  localparam int REF_TIMEOUT_MS  = 2000;
  localparam int STOP_CYCLES     = 5;
  localparam int IDLE_LIMIT      = 4000;
  localparam int PRESSURE_CYCLES = 300;
  localparam int DRAIN_CYCLES    = 4;
  localparam int DIR_ROWS        = 8;

  typedef enum logic [1:0] {
    SEQ_SEARCH,
    SEQ_REFWAIT,
    SEQ_DONE,
    SEQ_FAILED
  } seq_phase_t;

  typedef struct packed {
    logic                kind;
    logic [NJ-1:0][15:0] speed;
    logic [NJ-1:0][31:0] count;
  } homing_item_t;

  typedef struct packed {
    logic [NJ-1:0][1:0]  mode;
    logic [NJ-1:0][15:0] value;
    logic                done;
    logic                fail;
  } cmd_set_t;

  typedef struct packed {
    homing_item_t item;
    logic         typed;
    cmd_set_t     cmd;
  } dir_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  jhcs_in_if  in_ch ();
  jhcs_out_if out_ch ();

  joint_homing_calibration_sequencer #(
    .SETTLE_MS      (SETTLE_MS),
    .REF_TIMEOUT_MS (REF_TIMEOUT_MS),
    .STOP_CYCLES    (STOP_CYCLES)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_ch),
    .out_chan    (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // shadow of the sequencer
  jhcs_pkg::cfg_t cfg_shadow;
  seq_phase_t  seq_phase;
  logic [11:0] ms_elapsed;
  logic [NJ-1:0] moving;
  logic [2:0]  stop_run [NJ];
  logic [2:0]  hold_run;

  cmd_set_t cmd_queue [$];
  int send_idle;
  int recv_idle;
  int errors;
  int ticks_sent;
  int cmds_checked;
  int cfg_writes;
  int stall_seq;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic cmd_set_t cmd_all(jhcs_pkg::mode_t m, logic done, logic fail);
    cmd_set_t c;
    for (int j = 0; j < NJ; j++) begin
      c.mode[j]  = m;
      c.value[j] = '0;
    end
    c.done = done;
    c.fail = fail;
    return c;
  endfunction

  function automatic logic [15:0] dir_value(int j, logic [14:0] mag);
    return cfg_shadow.reverse_mask[j] ? -{1'b0, mag} : {1'b0, mag};
  endfunction

  // Advance the shadow by one item; returns 1 when the item yields a command set.
  function automatic bit predict_cmd(homing_item_t it, output cmd_set_t c);
    logic signed [16:0] sp;
    logic signed [32:0] cn;
    bit all_set;
    c = cmd_all(jhcs_pkg::MD_VOLT, 1'b0, 1'b0);
    if (!it.kind) begin
      if (ms_elapsed != jhcs_pkg::MS_MAX) ms_elapsed++;
      return 1'b0;
    end
    case (seq_phase)
      SEQ_SEARCH: begin
        if (hold_run >= jhcs_pkg::HOLD_ITEMS) begin
          c = cmd_all(jhcs_pkg::MD_REF, 1'b0, 1'b0);
          ms_elapsed = '0;
          seq_phase = SEQ_REFWAIT;
        end else begin
          if (ms_elapsed >= SETTLE_MS) begin
            for (int j = 0; j < NJ; j++) begin
              if (moving[j]) begin
                sp = $signed(it.speed[j]);
                if (sp < 0) sp = -sp;
                if (sp < jhcs_pkg::STILL_RPM) begin
                  if (stop_run[j] != jhcs_pkg::CNT3_MAX) stop_run[j]++;
                end else begin
                  stop_run[j] = '0;
                end
                if (stop_run[j] >= STOP_CYCLES) moving[j] = 1'b0;
              end
            end
            if (moving != '0) hold_run = '0;
            else if (hold_run != jhcs_pkg::CNT3_MAX) hold_run++;
          end
          for (int j = 0; j < NJ; j++) begin
            if (moving[j]) begin
              c.mode[j]  = jhcs_pkg::MD_VEL;
              c.value[j] = dir_value(j, cfg_shadow.search_speed);
            end else begin
              c.mode[j]  = jhcs_pkg::MD_CUR;
              c.value[j] = dir_value(j, cfg_shadow.hold_current);
            end
          end
        end
      end
      SEQ_REFWAIT: begin
        all_set = 1'b1;
        for (int j = 0; j < NJ; j++) begin
          cn = $signed(it.count[j]);
          if (cn < 0) cn = -cn;
          if (cn > jhcs_pkg::COUNT_TOL) all_set = 1'b0;
        end
        // timeout wins over counts in range
        if (ms_elapsed > REF_TIMEOUT_MS) begin
          seq_phase = SEQ_FAILED;
          c.fail = 1'b1;
        end else if (!all_set) begin
          c = cmd_all(jhcs_pkg::MD_REF, 1'b0, 1'b0);
        end else begin
          seq_phase = SEQ_DONE;
          c.done = 1'b1;
        end
      end
      SEQ_DONE: c.done = 1'b1;
      default:  c.fail = 1'b1;
    endcase
    return 1'b1;
  endfunction

  function automatic dir_row_t directed_row(int k);
    dir_row_t r;
    r = '0;
    r.item.kind = 1'b1;
    r.typed = 1'b1;
    r.cmd = cmd_all(jhcs_pkg::MD_VEL, 1'b0, 1'b0);
    case (k)
      1: begin
        r.item.speed = {NJ{16'h8000}};
        r.item.count = {NJ{32'h8000_0000}};
      end
      2: begin
        r.item.speed = {NJ{16'h7FFF}};
        r.item.count = {NJ{32'h7FFF_FFFF}};
      end
      3, 5: r.item.kind = 1'b0;
      4: begin
        // speeds and counts around the still and tolerance edges are ignored while settling
        r.item.speed[0] = 16'd4;
        r.item.speed[1] = 16'hFFFC;
        r.item.speed[2] = 16'd5;
        r.item.speed[3] = 16'hFFFB;
        r.item.count[0] = 32'd3;
        r.item.count[1] = 32'hFFFF_FFFD;
        r.item.count[2] = 32'd4;
        r.item.count[3] = 32'hFFFF_FFFC;
      end
      6: begin
        r.item.speed = {NJ{16'hAAAA}};
        r.item.count = {NJ{32'h5555_5555}};
      end
      7: begin
        r.item.speed = {NJ{16'h5555}};
        r.item.count = {NJ{32'hAAAA_AAAA}};
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] far_count();
    logic [31:0] v;
    case ($urandom_range(3))
      0: v = 32'd4;
      1: v = 32'hFFFF_FFFC;
      2: v = 32'h8000_0000;
      default: begin
        v = $urandom_range(32'h7FFF_FFFF, 4);
        if ($urandom_range(1)) v = -v;
      end
    endcase
    return v;
  endfunction

  function automatic homing_item_t rand_item(int tick_pct, logic [NJ-1:0] still_mask,
                                             bit near_ref);
    homing_item_t it;
    it.kind = ($urandom_range(99) >= tick_pct);
    for (int j = 0; j < NJ; j++) begin
      if (still_mask[j] && $urandom_range(99) >= 15) begin
        it.speed[j] = 16'($urandom_range(8)) - 16'd4;
      end else begin
        case ($urandom_range(7))
          0: it.speed[j] = 16'($urandom_range(12)) - 16'd6;
          1: it.speed[j] = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
          default: it.speed[j] = 16'($urandom);
        endcase
      end
      if (near_ref) begin
        it.count[j] = 32'($urandom_range(10)) - 32'd5;
      end else begin
        case ($urandom_range(7))
          0: it.count[j] = 32'($urandom_range(10)) - 32'd5;
          1: it.count[j] = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
          default: it.count[j] = $urandom;
        endcase
      end
    end
    // keep one joint off its reference so the wait goes on
    if (near_ref) it.count[$urandom_range(NJ-1)] = far_count();
    return it;
  endfunction

  task automatic push_item(homing_item_t it, bit typed, cmd_set_t typed_cmd);
    cmd_set_t c;
    bit has_cmd;
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.kind    <= it.kind;
    in_ch.speed_0 <= it.speed[0];
    in_ch.speed_1 <= it.speed[1];
    in_ch.speed_2 <= it.speed[2];
    in_ch.speed_3 <= it.speed[3];
    in_ch.speed_4 <= it.speed[4];
    in_ch.count_0 <= it.count[0];
    in_ch.count_1 <= it.count[1];
    in_ch.count_2 <= it.count[2];
    in_ch.count_3 <= it.count[3];
    in_ch.count_4 <= it.count[4];
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    has_cmd = predict_cmd(it, c);
    if (has_cmd) cmd_queue.push_back(typed ? typed_cmd : c);
    if (!it.kind) ticks_sent++;
  endtask

  task automatic push_rand(homing_item_t it);
    push_item(it, 1'b0, '0);
  endtask

  // drop valid and let the pipeline drain
  task automatic quiesce();
    in_ch.valid <= 1'b0;
    while (cmd_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(jhcs_pkg::reg_idx_t idx, logic [31:0] data);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    case (idx)
      jhcs_pkg::REG_REVERSE: cfg_shadow.reverse_mask = data[4:0];
      jhcs_pkg::REG_SPEED:   cfg_shadow.search_speed = data[14:0];
      default:               cfg_shadow.hold_current = data[14:0];
    endcase
    cfg_writes++;
  endtask

  task automatic set_cfg(logic [4:0] rev, logic [14:0] speed, logic [14:0] hold);
    quiesce();
    cfg_write(jhcs_pkg::REG_REVERSE, {27'd0, rev});
    cfg_write(jhcs_pkg::REG_SPEED, {17'd0, speed});
    cfg_write(jhcs_pkg::REG_HOLD, {17'd0, hold});
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  // receiver: random backpressure plus one long hold-off on request
  initial begin
    int stall_left;
    int stall_seen;
    stall_left = 0;
    stall_seen = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_seen != stall_seq) begin
        stall_seen = stall_seq;
        stall_left = PRESSURE_CYCLES;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle);
      end
    end
  end

  // compare each command set transfer against the oldest prediction
  initial begin
    cmd_set_t got;
    cmd_set_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got.mode[0]  = out_ch.mode_0;
        got.mode[1]  = out_ch.mode_1;
        got.mode[2]  = out_ch.mode_2;
        got.mode[3]  = out_ch.mode_3;
        got.mode[4]  = out_ch.mode_4;
        got.value[0] = out_ch.value_0;
        got.value[1] = out_ch.value_1;
        got.value[2] = out_ch.value_2;
        got.value[3] = out_ch.value_3;
        got.value[4] = out_ch.value_4;
        got.done     = out_ch.done_res;
        got.fail     = out_ch.failed;
        if (cmd_queue.size() == 0) begin
          $error("command set transfer with no prediction pending");
          errors++;
        end else begin
          want = cmd_queue.pop_front();
          cmds_checked++;
          for (int j = 0; j < NJ; j++) begin
            if (got.mode[j] !== want.mode[j]) begin
              $error("mode_%0d: expected %0d, got %0d", j, want.mode[j], got.mode[j]);
              errors++;
            end
            if (got.value[j] !== want.value[j]) begin
              $error("value_%0d: expected %0d, got %0d", j,
                     $signed(want.value[j]), $signed(got.value[j]));
              errors++;
            end
          end
          if (got.done !== want.done) begin
            $error("done_res: expected %0d, got %0d", want.done, got.done);
            errors++;
          end
          if (got.fail !== want.fail) begin
            $error("failed: expected %0d, got %0d", want.fail, got.fail);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) quiet = 0;
      else quiet++;
    end
    $display("tb_joint_homing_calibration_sequencer: done, errors");
    $finish;
  end

  initial begin
    homing_item_t it;
    dir_row_t row;
    logic [NJ-1:0] still;

    rst_n = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = 1'b0;
    in_ch.speed_0 = '0;
    in_ch.speed_1 = '0;
    in_ch.speed_2 = '0;
    in_ch.speed_3 = '0;
    in_ch.speed_4 = '0;
    in_ch.count_0 = '0;
    in_ch.count_1 = '0;
    in_ch.count_2 = '0;
    in_ch.count_3 = '0;
    in_ch.count_4 = '0;
    errors = 0;
    ticks_sent = 0;
    cmds_checked = 0;
    cfg_writes = 0;
    stall_seq = 0;
    send_idle = 30;
    recv_idle = 64;
    cfg_shadow = '0;
    seq_phase = SEQ_SEARCH;
    ms_elapsed = '0;
    moving = '1;
    for (int j = 0; j < NJ; j++) stop_run[j] = '0;
    hold_run = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: register defaults, field extremes, settling window
    for (int k = 0; k < DIR_ROWS; k++) begin
      row = directed_row(k);
      push_item(row.item, row.typed, row.cmd);
    end

    // mostly ticks: cross the settling boundary
    set_cfg(5'h1F, 15'h7FFF, 15'h7FFF);
    for (int k = 0; k < 250; k++) push_rand(rand_item(85, '0, 1'b0));

    // joints come to rest one after another
    send_idle = 64;
    recv_idle = 30;
    set_cfg(5'($urandom_range(31)), 15'($urandom_range(32767)), 15'($urandom_range(32767)));
    for (int k = 0; k < 250; k++) begin
      for (int j = 0; j < NJ; j++) still[j] = (k >= 30 * (j + 1));
      push_rand(rand_item(20, still, 1'b0));
    end

    send_idle = 0;
    recv_idle = 0;
    set_cfg(5'd0, 15'd0, 15'h7FFF);
    stall_seq <= stall_seq + 1;
    for (int k = 0; k < 16 && seq_phase == SEQ_SEARCH; k++) begin
      it = rand_item(0, '0, 1'b0);
      it.kind = 1'b1;
      it.speed = '0;
      push_rand(it);
    end
    for (int k = 0; k < 150; k++) push_rand(rand_item(50, '0, 1'b1));

    // counts at the tolerance edge end the reference wait
    if (seq_phase == SEQ_REFWAIT) begin
      it = rand_item(0, '0, 1'b0);
      it.kind = 1'b1;
      for (int j = 0; j < NJ; j++) it.count[j] = 32'($urandom_range(6)) - 32'd3;
      it.count[0] = 32'd3;
      it.count[1] = 32'hFFFF_FFFD;
      push_rand(it);
    end

    // terminal state holds whatever arrives
    set_cfg(5'($urandom_range(31)), 15'($urandom_range(32767)), 15'($urandom_range(32767)));
    for (int k = 0; k < 40; k++) push_rand(rand_item(30, '0, 1'b0));

    quiesce();
    $display("covered %0d ticks, %0d command sets, %0d register writes; sequence ended %s",
             ticks_sent, cmds_checked, cfg_writes, seq_phase.name());
    if (errors == 0 && cmd_queue.size() == 0) begin
      $display("tb_joint_homing_calibration_sequencer: done, clean");
    end else begin
      $display("tb_joint_homing_calibration_sequencer: done, errors");
    end
    $finish;
  end

endmodule
